// File: rtl/core/chm_pkg.sv
// chm_pkg: shared types and constants of the chained hash map
`default_nettype none
package chm_pkg;

    localparam int BUCKETS_DEF    = 64;
    localparam int POOL_NODES_DEF = 256;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CNT_OUT_W      = 9;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] result_value;
        logic               pool_full;
        logic [8:0]         entry_count;
        logic               is_empty;
    } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/chm_ram.sv
// chm_ram: generic one-write one-read synchronous ram with registered read
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/chained_hash_map.sv
// chained_hash_map: key-value map with chained buckets over a fixed node pool
//
// input channel s_valid/s_ready/s_data carries one request word: insert or
// update, lookup or remove. result channel m_valid/m_ready/m_data returns one
// word per request: found flag, old or found value (or absent value), pool
// full refusal, entry count and empty flag. cfg_valid/cfg_ready/cfg_data
// writes the absent value; cfg_ready is always high.
// one request at a time: the key is folded into a bucket, 8 key bits per
// cycle, then the chain head is read from the bucket ram, the chain is walked
// node by node over the node ram read port, for insert or remove the node and
// bucket rams are updated, and the result register is loaded.
// after reset the bucket ram is swept to empty, one bucket per cycle, with s_ready
// low. a stalled result holds in the output register and the next request is
// only finished once it has been taken.
`default_nettype none
module chained_hash_map #(
    parameter int BUCKETS    = chm_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire chm_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output chm_pkg::rsp_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data
);
    localparam int LW  = $clog2(POOL_NODES + 1);
    localparam int NAW = POOL_NODES > 1 ? $clog2(POOL_NODES) : 1;
    localparam int BW  = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int NW  = chm_pkg::KEY_W + chm_pkg::VAL_W + LW;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_MOD  = 4'd2;
    localparam logic [3:0] ST_HRD  = 4'd3;
    localparam logic [3:0] ST_HDAT = 4'd4;
    localparam logic [3:0] ST_WALK = 4'd5;
    localparam logic [3:0] ST_NDAT = 4'd6;
    localparam logic [3:0] ST_ACT  = 4'd7;
    localparam logic [3:0] ST_FDAT = 4'd8;
    localparam logic [3:0] ST_REM2 = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    logic [3:0]   state_reg, state_next;
    logic [1:0]   mode_reg, mode_next;
    logic [31:0]  key_reg, key_next;
    logic [31:0]  val_reg, val_next;
    logic [31:0]  mag_reg, mag_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic [1:0]   chunk_reg, chunk_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [31:0]  prev_key_reg, prev_key_next;
    logic [31:0]  prev_val_reg, prev_val_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [LW-1:0] hit_reg, hit_next;
    logic [31:0]  hit_val_reg, hit_val_next;
    logic [LW-1:0] hit_link_reg, hit_link_next;
    logic         found_reg, found_next;
    logic         full_reg, full_next;
    logic [31:0]  res_reg, res_next;
    logic [LW-1:0] free_reg, free_next;
    logic [LW-1:0] unused_reg, unused_next;
    logic [LW-1:0] count_reg, count_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [31:0]  absent_reg, absent_next;
    chm_pkg::rsp_t out_reg, out_next;
    logic         m_valid_reg, m_valid_next;

    logic          b_we;
    logic [BW-1:0] b_waddr, b_raddr;
    logic [LW-1:0] b_wdata, b_rdata;
    logic           n_we;
    logic [NAW-1:0] n_waddr, n_raddr;
    logic [NW-1:0]  n_wdata, n_rdata;
    logic [31:0]    n_key, n_val;
    logic [LW-1:0]  n_link;

    logic [BW-1:0] rem_step;
    logic [BW:0]   rem_tmp;

    chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bucket_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    assign n_key  = n_rdata[NW-1 -: 32];
    assign n_val  = n_rdata[LW +: 32];
    assign n_link = n_rdata[LW-1:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // bucket fold: eight key bits per cycle, msb first
    always_comb begin
        rem_step = rem_reg;
        rem_tmp  = '0;
        for (int i = 0; i < 8; i++) begin
            rem_tmp = {rem_step, mag_reg[31-i]};
            if (rem_tmp >= (BW+1)'(BUCKETS)) begin
                rem_tmp = rem_tmp - (BW+1)'(BUCKETS);
            end
            rem_step = rem_tmp[BW-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        chunk_next    = chunk_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_key_next = prev_key_reg;
        prev_val_next = prev_val_reg;
        steps_next    = steps_reg;
        hit_next      = hit_reg;
        hit_val_next  = hit_val_reg;
        hit_link_next = hit_link_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        res_next      = res_reg;
        free_next     = free_reg;
        unused_next   = unused_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        absent_next   = absent_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        b_we    = 1'b0;
        b_waddr = rem_reg;
        b_wdata = '0;
        b_raddr = rem_reg;
        n_we    = 1'b0;
        n_waddr = '0;
        n_wdata = '0;
        n_raddr = NAW'(cur_reg - LW'(1));

        if (cfg_valid) begin
            absent_next = cfg_data;
        end

        case (state_reg)
            ST_CLR: begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    key_next   = s_data.key;
                    val_next   = s_data.value;
                    mag_next   = s_data.key[31] ? (32'd0 - s_data.key) : s_data.key;
                    rem_next   = '0;
                    chunk_next = '0;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    res_next   = absent_reg;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                rem_next   = rem_step;
                mag_next   = {mag_reg[23:0], 8'd0};
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3) begin
                    if (mode_reg inside {chm_pkg::MODE_INSERT, chm_pkg::MODE_LOOKUP,
                                         chm_pkg::MODE_REMOVE}) begin
                        state_next = ST_HRD;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_HRD: begin
                state_next = ST_HDAT;
            end
            ST_HDAT: begin
                head_next  = b_rdata;
                cur_next   = b_rdata;
                prev_next  = '0;
                steps_next = '0;
                hit_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (cur_reg != '0 && cur_reg <= LW'(POOL_NODES)
                    && steps_reg < LW'(POOL_NODES)) begin
                    state_next = ST_NDAT;
                end else begin
                    prev_next  = '0;
                    state_next = ST_ACT;
                end
            end
            ST_NDAT: begin
                if (n_key == key_reg) begin
                    hit_next      = cur_reg;
                    hit_val_next  = n_val;
                    hit_link_next = n_link;
                    state_next    = ST_ACT;
                end else begin
                    prev_next     = cur_reg;
                    prev_key_next = n_key;
                    prev_val_next = n_val;
                    cur_next      = n_link;
                    steps_next    = steps_reg + LW'(1);
                    state_next    = ST_WALK;
                end
            end
            ST_ACT: begin
                state_next = ST_FIN;
                if (hit_reg != '0) begin
                    found_next = 1'b1;
                    res_next   = hit_val_reg;
                    if (mode_reg == chm_pkg::MODE_INSERT) begin
                        n_we    = 1'b1;
                        n_waddr = NAW'(hit_reg - LW'(1));
                        n_wdata = {key_reg, val_reg, hit_link_reg};
                    end else if (mode_reg == chm_pkg::MODE_REMOVE) begin
                        if (prev_reg != '0) begin
                            n_we       = 1'b1;
                            n_waddr    = NAW'(prev_reg - LW'(1));
                            n_wdata    = {prev_key_reg, prev_val_reg, hit_link_reg};
                            state_next = ST_REM2;
                        end else begin
                            b_we       = 1'b1;
                            b_wdata    = hit_link_reg;
                            n_we       = 1'b1;
                            n_waddr    = NAW'(hit_reg - LW'(1));
                            n_wdata    = {key_reg, hit_val_reg, free_reg};
                            free_next  = hit_reg;
                            count_next = count_reg - LW'(1);
                        end
                    end
                end else if (mode_reg == chm_pkg::MODE_INSERT) begin
                    if (count_reg >= LW'(POOL_NODES)) begin
                        full_next = 1'b1;
                    end else if (free_reg != '0 && free_reg <= LW'(POOL_NODES)) begin
                        n_raddr    = NAW'(free_reg - LW'(1));
                        state_next = ST_FDAT;
                    end else if (unused_reg < LW'(POOL_NODES)) begin
                        n_we        = 1'b1;
                        n_waddr     = NAW'(unused_reg);
                        n_wdata     = {key_reg, val_reg, head_reg};
                        b_we        = 1'b1;
                        b_wdata     = unused_reg + LW'(1);
                        unused_next = unused_reg + LW'(1);
                        count_next  = count_reg + LW'(1);
                    end else begin
                        full_next = 1'b1;
                    end
                end
            end
            ST_FDAT: begin
                n_we       = 1'b1;
                n_waddr    = NAW'(free_reg - LW'(1));
                n_wdata    = {key_reg, val_reg, head_reg};
                b_we       = 1'b1;
                b_wdata    = free_reg;
                free_next  = n_link;
                count_next = count_reg + LW'(1);
                state_next = ST_FIN;
            end
            ST_REM2: begin
                n_we       = 1'b1;
                n_waddr    = NAW'(hit_reg - LW'(1));
                n_wdata    = {key_reg, hit_val_reg, free_reg};
                free_next  = hit_reg;
                count_next = count_reg - LW'(1);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.found        = found_reg;
                    out_next.result_value = res_reg;
                    out_next.pool_full    = full_reg;
                    out_next.entry_count  = chm_pkg::CNT_OUT_W'(count_reg);
                    out_next.is_empty     = (count_reg == '0);
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            free_reg    <= '0;
            unused_reg  <= '0;
            count_reg   <= '0;
            absent_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            free_reg    <= free_next;
            unused_reg  <= unused_next;
            count_reg   <= count_next;
            absent_reg  <= absent_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        chunk_reg    <= chunk_next;
        head_reg     <= head_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        prev_val_reg <= prev_val_next;
        steps_reg    <= steps_next;
        hit_reg      <= hit_next;
        hit_val_reg  <= hit_val_next;
        hit_link_reg <= hit_link_next;
        found_reg    <= found_next;
        full_reg     <= full_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LW'(POOL_NODES))
        else $error("entry count beyond pool size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + LW'(1))
        || (count_reg == $past(count_reg) - LW'(1)))
        else $error("entry count moved by more than one");

    a_count_used: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= unused_reg)
        else $error("more entries than nodes ever handed out");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");
`endif
endmodule
`default_nettype wire
